FILE: rtl/msort_pkg.sv
`timescale 1ns / 1ps
package msort_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;

  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int WID_W  = CNT_W + 1;
  localparam int SUM_W  = CNT_W + 2;

  localparam int UPC_W  = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 3;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_PASS_INIT = 4'd2;
  localparam logic [OP_W-1:0] OP_LO_CLEAR  = 4'd3;
  localparam logic [OP_W-1:0] OP_RUN_SETUP = 4'd4;
  localparam logic [OP_W-1:0] OP_MERGE     = 4'd5;
  localparam logic [OP_W-1:0] OP_LO_ADV    = 4'd6;
  localparam logic [OP_W-1:0] OP_PASS_ADV  = 4'd7;
  localparam logic [OP_W-1:0] OP_EMIT_INIT = 4'd8;
  localparam logic [OP_W-1:0] OP_EMIT      = 4'd9;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd10;

  // jump conditions
  localparam logic [COND_W-1:0] CND_NEVER      = 3'd0;
  localparam logic [COND_W-1:0] CND_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] CND_NOT_FINAL  = 3'd2;
  localparam logic [COND_W-1:0] CND_WIDTH_DONE = 3'd3;
  localparam logic [COND_W-1:0] CND_LO_DONE    = 3'd4;
  localparam logic [COND_W-1:0] CND_RUN_BUSY   = 3'd5;
  localparam logic [COND_W-1:0] CND_EMIT_BUSY  = 3'd6;

  // program steps
  localparam logic [UPC_W-1:0] ST_LOAD      = 4'd0;
  localparam logic [UPC_W-1:0] ST_PASS_INIT = 4'd1;
  localparam logic [UPC_W-1:0] ST_PASS_TEST = 4'd2;
  localparam logic [UPC_W-1:0] ST_RUN_TEST  = 4'd3;
  localparam logic [UPC_W-1:0] ST_MERGE     = 4'd4;
  localparam logic [UPC_W-1:0] ST_RUN_NEXT  = 4'd5;
  localparam logic [UPC_W-1:0] ST_PASS_ADV  = 4'd6;
  localparam logic [UPC_W-1:0] ST_EMIT_INIT = 4'd7;
  localparam logic [UPC_W-1:0] ST_EMIT      = 4'd8;
  localparam logic [UPC_W-1:0] ST_DONE      = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
  } msort_ctrl_t;

  typedef struct packed {
    logic final_acc;
    logic width_done;
    logic lo_done;
    logic run_last;
    logic emit_last;
  } msort_flags_t;

  function automatic msort_ctrl_t ucode(input logic [UPC_W-1:0] step);
    msort_ctrl_t w;
    w = '{op: OP_NONE, cond: CND_ALWAYS, target: ST_LOAD};
    unique case (step)
      ST_LOAD:      w = '{op: OP_LOAD,      cond: CND_NOT_FINAL,  target: ST_LOAD};
      ST_PASS_INIT: w = '{op: OP_PASS_INIT, cond: CND_NEVER,      target: ST_LOAD};
      ST_PASS_TEST: w = '{op: OP_LO_CLEAR,  cond: CND_WIDTH_DONE, target: ST_EMIT_INIT};
      ST_RUN_TEST:  w = '{op: OP_RUN_SETUP, cond: CND_LO_DONE,    target: ST_PASS_ADV};
      ST_MERGE:     w = '{op: OP_MERGE,     cond: CND_RUN_BUSY,   target: ST_MERGE};
      ST_RUN_NEXT:  w = '{op: OP_LO_ADV,    cond: CND_ALWAYS,     target: ST_RUN_TEST};
      ST_PASS_ADV:  w = '{op: OP_PASS_ADV,  cond: CND_ALWAYS,     target: ST_PASS_TEST};
      ST_EMIT_INIT: w = '{op: OP_EMIT_INIT, cond: CND_NEVER,      target: ST_LOAD};
      ST_EMIT:      w = '{op: OP_EMIT,      cond: CND_EMIT_BUSY,  target: ST_EMIT};
      ST_DONE:      w = '{op: OP_CLEAR,     cond: CND_ALWAYS,     target: ST_LOAD};
      default:      w = '{op: OP_NONE,      cond: CND_ALWAYS,     target: ST_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VALUE_W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_data(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] t;
    t = 64'(d);
    return t[VALUE_W-1:0];
  endfunction

endpackage

FILE: rtl/msort_useq.sv
`timescale 1ns / 1ps
module msort_useq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msort_pkg::msort_flags_t flags,
  output msort_pkg::msort_ctrl_t  ctrl
);
  import msort_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  msort_ctrl_t      word;
  logic             taken;

  assign word = ucode(upc_r);
  assign ctrl = word;

  always_comb begin
    unique case (word.cond)
      CND_NEVER:      taken = 1'b0;
      CND_ALWAYS:     taken = 1'b1;
      CND_NOT_FINAL:  taken = !flags.final_acc;
      CND_WIDTH_DONE: taken = flags.width_done;
      CND_LO_DONE:    taken = flags.lo_done;
      CND_RUN_BUSY:   taken = !flags.run_last;
      CND_EMIT_BUSY:  taken = !flags.emit_last;
      default:        taken = 1'b1;
    endcase
    upc_nxt = taken ? word.target : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: rtl/merge_sort_engine.sv
`timescale 1ns / 1ps
// Load: one accepted beat per cycle; the beat with in_final_req starts the sort.
// Sort of n elements: ceil(log2 n) passes; each pass merges pairs of runs of the current
// width from one store into the other, then doubles the width. Then n output beats follow
// at up to one per cycle as out_ready allows, and a cleanup step clears the count.
// One set is worked on at a time; input is held off from the final beat to cleanup.
// Reset clears the sequencer, counters and output valid; the stores are not cleared.
module merge_sort_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [msort_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_final_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [msort_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                                out_end_of_run,
  output logic                                out_overflowed
);
  import msort_pkg::*;

  msort_ctrl_t  ctrl;
  msort_flags_t flags;

  logic [DATA_WIDTH-1:0] elem_mem [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] scr_mem  [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] elem_rd_a_r, elem_rd_b_r, scr_rd_a_r, scr_rd_b_r;
  logic [DATA_WIDTH-1:0] rd_a, rd_b, merge_data;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [WID_W-1:0] width_r, width_nxt;
  logic [SUM_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic             src_sel_r, src_sel_nxt;

  logic [CNT_W-1:0] a_inc, k_inc, mid_calc, hi_calc;
  logic [SUM_W-1:0] sum_mid, sum_hi, n_ext;
  logic             in_acc, take_a, out_load, has_room;
  logic             elem_we, scr_we;
  logic [ADDR_W-1:0] elem_waddr;
  logic [DATA_WIDTH-1:0] elem_wdata;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r;
  logic                  out_end_r, out_ovf_r;

  msort_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_ready = (ctrl.op == OP_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign has_room = (count_r < CNT_W'(MAX_ITEMS));

  assign rd_a = src_sel_r ? scr_rd_a_r : elem_rd_a_r;
  assign rd_b = src_sel_r ? scr_rd_b_r : elem_rd_b_r;

  assign a_inc = a_r + CNT_W'(1);
  assign k_inc = k_r + CNT_W'(1);

  // Ties go to the left run.
  assign take_a = (a_r < mid_r) && ((b_r >= hi_r) || ($signed(rd_a) <= $signed(rd_b)));
  assign merge_data = take_a ? rd_a : rd_b;

  assign n_ext    = SUM_W'(count_r);
  assign sum_mid  = lo_r + SUM_W'(width_r);
  assign sum_hi   = lo_r + SUM_W'({width_r, 1'b0});
  assign mid_calc = (sum_mid > n_ext) ? count_r : sum_mid[CNT_W-1:0];
  assign hi_calc  = (sum_hi > n_ext) ? count_r : sum_hi[CNT_W-1:0];

  assign out_load = (ctrl.op == OP_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    flags.final_acc  = in_acc && in_final_req;
    flags.width_done = (width_r >= WID_W'(count_r));
    flags.lo_done    = (lo_r >= n_ext);
    flags.run_last   = (k_inc == hi_r);
    flags.emit_last  = out_load && (a_inc == count_r);
  end

  always_comb begin
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    width_nxt   = width_r;
    lo_nxt      = lo_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    k_nxt       = k_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    src_sel_nxt = src_sel_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_PASS_INIT: begin
        width_nxt   = WID_W'(1);
        src_sel_nxt = 1'b0;
      end
      OP_LO_CLEAR: begin
        lo_nxt = '0;
      end
      OP_RUN_SETUP: begin
        a_nxt   = lo_r[CNT_W-1:0];
        k_nxt   = lo_r[CNT_W-1:0];
        mid_nxt = mid_calc;
        b_nxt   = mid_calc;
        hi_nxt  = hi_calc;
      end
      OP_MERGE: begin
        k_nxt = k_inc;
        if (take_a) begin
          a_nxt = a_inc;
        end else begin
          b_nxt = b_r + CNT_W'(1);
        end
      end
      OP_LO_ADV: begin
        lo_nxt = sum_hi;
      end
      OP_PASS_ADV: begin
        width_nxt   = {width_r[WID_W-2:0], 1'b0};
        src_sel_nxt = ~src_sel_r;
      end
      OP_EMIT_INIT: begin
        a_nxt = '0;
      end
      OP_EMIT: begin
        if (out_load) begin
          a_nxt = a_inc;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  // Merge writes go to the bank opposite the source.
  assign elem_we    = ((ctrl.op == OP_LOAD) && in_acc && has_room) ||
                      ((ctrl.op == OP_MERGE) && src_sel_r);
  assign elem_waddr = (ctrl.op == OP_LOAD) ? count_r[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign elem_wdata = (ctrl.op == OP_LOAD) ? to_data(in_value) : merge_data;
  assign scr_we     = (ctrl.op == OP_MERGE) && !src_sel_r;

  // Read at the next pointers so the heads always hold src[a_r] and src[b_r].
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_rd_a_r <= elem_mem[a_nxt[ADDR_W-1:0]];
    elem_rd_b_r <= elem_mem[b_nxt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[k_r[ADDR_W-1:0]] <= merge_data;
    end
    scr_rd_a_r <= scr_mem[a_nxt[ADDR_W-1:0]];
    scr_rd_b_r <= scr_mem[b_nxt[ADDR_W-1:0]];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      src_sel_r   <= 1'b0;
      width_r     <= WID_W'(1);
      lo_r        <= '0;
      a_r         <= '0;
      b_r         <= '0;
      k_r         <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      src_sel_r   <= src_sel_nxt;
      width_r     <= width_nxt;
      lo_r        <= lo_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      k_r         <= k_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= from_data(rd_a);
      out_end_r   <= (a_inc == count_r);
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflowed   = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_merge_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_MERGE) |-> (k_r < hi_r) && (a_r <= mid_r) && (b_r <= hi_r))
    else $error("merge pointers out of run");

  a_final_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_req) |=> !in_ready)
    else $error("input taken after final beat");

  a_emit_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> $stable(ovf_r))
    else $error("overflow flag changed while emitting");

endmodule
